[rtl/smtps_pkg.sv]
`default_nettype none
package smtps_pkg;

    localparam int unsigned CODE_TEMP_FAIL = 400;
    localparam int unsigned CODE_PERM_FAIL = 500;

    typedef enum logic [1:0] {
        ACT_REPLY   = 2'd0,
        ACT_CONNECT = 2'd1,
        ACT_CLOSED  = 2'd2,
        ACT_MAIL    = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        CMD_NONE  = 4'd0,
        CMD_OPEN  = 4'd1,
        CMD_CLOSE = 4'd2,
        CMD_EHLO  = 4'd3,
        CMD_HELO  = 4'd4,
        CMD_MAIL  = 4'd5,
        CMD_RCPT  = 4'd6,
        CMD_DATA  = 4'd7,
        CMD_RSET  = 4'd8
    } cmd_t;

    typedef enum logic [11:0] {
        ST_CLOSED     = 12'b0000_0000_0001,
        ST_CONNECTING = 12'b0000_0000_0010,
        ST_GREETING   = 12'b0000_0000_0100,
        ST_IDLE       = 12'b0000_0000_1000,
        ST_EHLO       = 12'b0000_0001_0000,
        ST_HELO       = 12'b0000_0010_0000,
        ST_MAILFROM   = 12'b0000_0100_0000,
        ST_RCPT       = 12'b0000_1000_0000,
        ST_DATA       = 12'b0001_0000_0000,
        ST_BODY       = 12'b0010_0000_0000,
        ST_RSET       = 12'b0100_0000_0000,
        ST_QUIT       = 12'b1000_0000_0000
    } state_t;

    typedef struct packed {
        logic mail_sent;
        logic mail_dropped;
        logic queue_overflow;
        logic unexpected_reply;
    } flags_t;

    function automatic logic [3:0] state_code(input state_t st);
        logic [3:0] code;
        case (st)
            ST_CLOSED:     code = 4'd0;
            ST_CONNECTING: code = 4'd1;
            ST_GREETING:   code = 4'd2;
            ST_IDLE:       code = 4'd3;
            ST_EHLO:       code = 4'd4;
            ST_HELO:       code = 4'd5;
            ST_MAILFROM:   code = 4'd6;
            ST_RCPT:       code = 4'd7;
            ST_DATA:       code = 4'd8;
            ST_BODY:       code = 4'd9;
            ST_RSET:       code = 4'd10;
            ST_QUIT:       code = 4'd11;
            default:       code = 4'd0;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

[rtl/smtps_step.sv]
`default_nettype none
module smtps_step #(
    parameter int unsigned MAX_PENDING = 255,
    parameter int unsigned CNT_W       = 8
) (
    input  var smtps_pkg::state_t  state,
    input  wire [CNT_W-1:0]        count,
    input  wire [1:0]              action,
    input  wire [9:0]              reply_code,
    input  wire                    continued,
    input  wire                    connect_failed,
    output smtps_pkg::state_t      state_next,
    output logic [CNT_W-1:0]       count_next,
    output smtps_pkg::cmd_t        command,
    output smtps_pkg::flags_t      flags
);

    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_PENDING);
    localparam logic [9:0]       TEMP_FAIL = 10'(smtps_pkg::CODE_TEMP_FAIL);
    localparam logic [9:0]       PERM_FAIL = 10'(smtps_pkg::CODE_PERM_FAIL);

    logic [CNT_W-1:0] count_dec;
    logic [CNT_W-1:0] count_inc;
    logic             temp_fail;
    logic             perm_fail;

    assign count_dec = (count == '0) ? '0 : count - CNT_W'(1);
    assign count_inc = count + CNT_W'(1);
    assign temp_fail = reply_code >= TEMP_FAIL;
    assign perm_fail = reply_code >= PERM_FAIL;

    always_comb
    begin
        state_next = state;
        count_next = count;
        command    = smtps_pkg::CMD_NONE;
        flags      = '0;
        case (smtps_pkg::action_t'(action))
            smtps_pkg::ACT_REPLY:
            begin
                if (state inside {smtps_pkg::ST_CLOSED, smtps_pkg::ST_CONNECTING})
                begin
                    flags.unexpected_reply = 1'b1;
                end
                else if (state == smtps_pkg::ST_RSET)
                begin
                    state_next = (count != '0) ? smtps_pkg::ST_MAILFROM : smtps_pkg::ST_IDLE;
                    command    = (count != '0) ? smtps_pkg::CMD_MAIL : smtps_pkg::CMD_NONE;
                end
                else if (!continued)
                begin
                    case (state)
                        smtps_pkg::ST_GREETING:
                        begin
                            state_next = temp_fail ? smtps_pkg::ST_CLOSED : smtps_pkg::ST_EHLO;
                            command    = temp_fail ? smtps_pkg::CMD_CLOSE : smtps_pkg::CMD_EHLO;
                        end
                        smtps_pkg::ST_EHLO, smtps_pkg::ST_HELO:
                        begin
                            if (perm_fail && state == smtps_pkg::ST_EHLO)
                            begin
                                state_next = smtps_pkg::ST_HELO;
                                command    = smtps_pkg::CMD_HELO;
                            end
                            else if (temp_fail)
                            begin
                                state_next = smtps_pkg::ST_CLOSED;
                                command    = smtps_pkg::CMD_CLOSE;
                            end
                            else if (count != '0)
                            begin
                                state_next = smtps_pkg::ST_MAILFROM;
                                command    = smtps_pkg::CMD_MAIL;
                            end
                            else
                            begin
                                state_next = smtps_pkg::ST_IDLE;
                            end
                        end
                        smtps_pkg::ST_MAILFROM, smtps_pkg::ST_RCPT,
                        smtps_pkg::ST_DATA, smtps_pkg::ST_BODY:
                        begin
                            if (perm_fail)
                            begin
                                count_next         = count_dec;
                                flags.mail_dropped = 1'b1;
                                command            = smtps_pkg::CMD_RSET;
                                state_next         = smtps_pkg::ST_RSET;
                            end
                            else if (!temp_fail)
                            begin
                                case (state)
                                    smtps_pkg::ST_MAILFROM:
                                    begin
                                        command    = smtps_pkg::CMD_RCPT;
                                        state_next = smtps_pkg::ST_RCPT;
                                    end
                                    smtps_pkg::ST_RCPT:
                                    begin
                                        command    = smtps_pkg::CMD_DATA;
                                        state_next = smtps_pkg::ST_DATA;
                                    end
                                    smtps_pkg::ST_DATA:
                                    begin
                                        state_next = smtps_pkg::ST_BODY;
                                    end
                                    default:
                                    begin
                                        count_next      = count_dec;
                                        flags.mail_sent = 1'b1;
                                        state_next      = (count_dec != '0) ?
                                            smtps_pkg::ST_MAILFROM : smtps_pkg::ST_IDLE;
                                        command         = (count_dec != '0) ?
                                            smtps_pkg::CMD_MAIL : smtps_pkg::CMD_NONE;
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            smtps_pkg::ACT_CONNECT:
            begin
                if (state == smtps_pkg::ST_CONNECTING)
                begin
                    state_next = connect_failed ? smtps_pkg::ST_CLOSED : smtps_pkg::ST_GREETING;
                end
            end
            smtps_pkg::ACT_CLOSED:
            begin
                if (state != smtps_pkg::ST_CLOSED)
                begin
                    command = smtps_pkg::CMD_CLOSE;
                end
                state_next = smtps_pkg::ST_CLOSED;
            end
            default:
            begin
                if (count >= MAX_CNT)
                begin
                    flags.queue_overflow = 1'b1;
                end
                else
                begin
                    count_next = count_inc;
                    if (state == smtps_pkg::ST_CLOSED)
                    begin
                        command    = smtps_pkg::CMD_OPEN;
                        state_next = smtps_pkg::ST_CONNECTING;
                    end
                    else if (state == smtps_pkg::ST_IDLE)
                    begin
                        command    = smtps_pkg::CMD_MAIL;
                        state_next = smtps_pkg::ST_MAILFROM;
                    end
                end
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/smtp_client_sequencer.sv]
`default_nettype none
// SMTP client command sequencer. Each input beat is one event (server reply
// line, connect result, link close or new mail); each produces exactly one
// output beat with the next command, the sent/dropped/overflow/unexpected
// flags, the protocol state and the pending mail count after the event.
// An event passes an input register, then the state table and counter
// update, then the result register, and one event per cycle is sustained
// while the output side does not stall. The pending count saturates at
// MAX_PENDING; pending_count shows its low 8 bits.
module smtp_client_sequencer #(
    parameter int unsigned MAX_PENDING = 255
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire [1:0]  action,
    input  wire [9:0]  reply_code,
    input  wire        continued,
    input  wire        connect_failed,
    output logic       out_valid,
    input  wire        out_stall,
    output logic [3:0] command,
    output logic       mail_sent,
    output logic       mail_dropped,
    output logic       queue_overflow,
    output logic       unexpected_reply,
    output logic [3:0] current_state,
    output logic [7:0] pending_count
);

    localparam int unsigned CNT_W = $clog2(MAX_PENDING + 1);

    logic             in_valid_reg;
    logic [1:0]       action_reg;
    logic [9:0]       reply_code_reg;
    logic             continued_reg;
    logic             connect_failed_reg;

    smtps_pkg::state_t state_reg;
    smtps_pkg::state_t state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    smtps_pkg::cmd_t   cmd_next;
    smtps_pkg::flags_t flags_next;

    logic              out_valid_reg;
    logic [3:0]        command_reg;
    smtps_pkg::flags_t flags_reg;
    logic [3:0]        state_code_reg;
    logic [7:0]        pending_reg;

    logic              advance;
    logic [CNT_W+7:0]  count_ext;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign count_ext = {8'd0, count_next};

    smtps_step #(
        .MAX_PENDING (MAX_PENDING),
        .CNT_W       (CNT_W)
    ) u_step (
        .state          (state_reg),
        .count          (count_reg),
        .action         (action_reg),
        .reply_code     (reply_code_reg),
        .continued      (continued_reg),
        .connect_failed (connect_failed_reg),
        .state_next     (state_next),
        .count_next     (count_next),
        .command        (cmd_next),
        .flags          (flags_next)
    );

    // input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            action_reg         <= action;
            reply_code_reg     <= reply_code;
            continued_reg      <= continued;
            connect_failed_reg <= connect_failed;
        end
    end

    // protocol state and pending count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smtps_pkg::ST_CLOSED;
            count_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            command_reg    <= cmd_next;
            flags_reg      <= flags_next;
            state_code_reg <= smtps_pkg::state_code(state_next);
            pending_reg    <= count_ext[7:0];
        end
    end

    assign out_valid        = out_valid_reg;
    assign command          = command_reg;
    assign mail_sent        = flags_reg.mail_sent;
    assign mail_dropped     = flags_reg.mail_dropped;
    assign queue_overflow   = flags_reg.queue_overflow;
    assign unexpected_reply = flags_reg.unexpected_reply;
    assign current_state    = state_code_reg;
    assign pending_count    = pending_reg;

endmodule
`default_nettype wire

[sim/smtp_seq_monitor.sv]
module smtp_seq_monitor
    import smtps_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    input  wire        in_stall,
    input  wire [1:0]  action,
    input  wire [9:0]  reply_code,
    input  wire        continued,
    input  wire        connect_failed,
    input  wire        out_valid,
    input  wire        out_stall,
    input  wire [3:0]  command,
    input  wire        mail_sent,
    input  wire        mail_dropped,
    input  wire        queue_overflow,
    input  wire        unexpected_reply,
    input  wire [3:0]  current_state,
    input  wire [7:0]  pending_count,
    input  wire        end_of_test,
    output int         fail_count,
    output int         outstanding
);

    localparam int unsigned QUEUE_LIMIT = 255;

    typedef enum logic [3:0] {
        PH_CLOSED     = 4'd0,
        PH_CONNECTING = 4'd1,
        PH_GREETING   = 4'd2,
        PH_IDLE       = 4'd3,
        PH_EHLO       = 4'd4,
        PH_HELO       = 4'd5,
        PH_MAILFROM   = 4'd6,
        PH_RCPT       = 4'd7,
        PH_DATA       = 4'd8,
        PH_BODY       = 4'd9,
        PH_RSET       = 4'd10,
        PH_QUIT       = 4'd11
    } phase_t;

    typedef struct packed {
        cmd_t       command;
        logic       sent;
        logic       dropped;
        logic       overflow;
        logic       unexpected;
        logic [3:0] phase;
        logic [7:0] count;
    } outcome_t;

    phase_t      session_phase;
    int unsigned mails_waiting;
    outcome_t    expected_outcomes[$];
    outcome_t    oldest;
    bit          leftovers_checked;

    initial
    begin
        fail_count        = 0;
        outstanding       = 0;
        leftovers_checked = 1'b0;
        session_phase     = PH_CLOSED;
        mails_waiting     = 0;
    end

    task automatic report_error(input string msg);
        if (fail_count < 100)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
        begin
            report_error($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    function automatic cmd_t next_from_idle();
        if (mails_waiting > 0)
        begin
            session_phase = PH_MAILFROM;
            return CMD_MAIL;
        end
        session_phase = PH_IDLE;
        return CMD_NONE;
    endfunction

    function automatic void drop_head();
        if (mails_waiting > 0)
        begin
            mails_waiting--;
        end
    endfunction

    function automatic void predict_outcome(input action_t act, input logic [9:0] code,
                                            input logic cont, input logic failed);
        outcome_t o;
        phase_t   was;
        o         = '0;
        o.command = CMD_NONE;
        was       = session_phase;
        case (act)
            ACT_REPLY:
            begin
                if (was == PH_CLOSED || was == PH_CONNECTING)
                begin
                    o.unexpected = 1'b1;
                end
                else if (was == PH_RSET)
                begin
                    o.command = next_from_idle();
                end
                else if (!cont)
                begin
                    case (was)
                        PH_GREETING:
                        begin
                            if (code >= CODE_TEMP_FAIL)
                            begin
                                o.command     = CMD_CLOSE;
                                session_phase = PH_CLOSED;
                            end
                            else
                            begin
                                o.command     = CMD_EHLO;
                                session_phase = PH_EHLO;
                            end
                        end
                        PH_EHLO:
                        begin
                            if (code >= CODE_PERM_FAIL)
                            begin
                                o.command     = CMD_HELO;
                                session_phase = PH_HELO;
                            end
                            else if (code >= CODE_TEMP_FAIL)
                            begin
                                o.command     = CMD_CLOSE;
                                session_phase = PH_CLOSED;
                            end
                            else
                            begin
                                o.command = next_from_idle();
                            end
                        end
                        PH_HELO:
                        begin
                            if (code >= CODE_TEMP_FAIL)
                            begin
                                o.command     = CMD_CLOSE;
                                session_phase = PH_CLOSED;
                            end
                            else
                            begin
                                o.command = next_from_idle();
                            end
                        end
                        PH_MAILFROM, PH_RCPT, PH_DATA, PH_BODY:
                        begin
                            if (code >= CODE_PERM_FAIL)
                            begin
                                drop_head();
                                o.dropped     = 1'b1;
                                o.command     = CMD_RSET;
                                session_phase = PH_RSET;
                            end
                            else if (code < CODE_TEMP_FAIL)
                            begin
                                case (was)
                                    PH_MAILFROM:
                                    begin
                                        o.command     = CMD_RCPT;
                                        session_phase = PH_RCPT;
                                    end
                                    PH_RCPT:
                                    begin
                                        o.command     = CMD_DATA;
                                        session_phase = PH_DATA;
                                    end
                                    PH_DATA:
                                    begin
                                        session_phase = PH_BODY;
                                    end
                                    default:
                                    begin
                                        drop_head();
                                        o.sent    = 1'b1;
                                        o.command = next_from_idle();
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ACT_CONNECT:
            begin
                if (was == PH_CONNECTING)
                begin
                    session_phase = failed ? PH_CLOSED : PH_GREETING;
                end
            end
            ACT_CLOSED:
            begin
                if (was != PH_CLOSED)
                begin
                    o.command = CMD_CLOSE;
                end
                session_phase = PH_CLOSED;
            end
            default:
            begin
                if (mails_waiting >= QUEUE_LIMIT)
                begin
                    o.overflow = 1'b1;
                end
                else
                begin
                    mails_waiting++;
                    if (was == PH_CLOSED)
                    begin
                        o.command     = CMD_OPEN;
                        session_phase = PH_CONNECTING;
                    end
                    else if (was == PH_IDLE)
                    begin
                        o.command = next_from_idle();
                    end
                end
            end
        endcase
        o.phase = session_phase;
        o.count = mails_waiting[7:0];
        expected_outcomes.push_back(o);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_phase = PH_CLOSED;
            mails_waiting = 0;
            expected_outcomes.delete();
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    report_error("result beat with nothing expected");
                end
                else
                begin
                    oldest = expected_outcomes.pop_front();
                    check_field("command", 8'(command), 8'(oldest.command));
                    check_field("mail_sent", 8'(mail_sent), 8'(oldest.sent));
                    check_field("mail_dropped", 8'(mail_dropped), 8'(oldest.dropped));
                    check_field("queue_overflow", 8'(queue_overflow), 8'(oldest.overflow));
                    check_field("unexpected_reply", 8'(unexpected_reply),
                                8'(oldest.unexpected));
                    check_field("current_state", 8'(current_state), 8'(oldest.phase));
                    check_field("pending_count", pending_count, oldest.count);
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_outcome(action_t'(action), reply_code, continued, connect_failed);
            end
            outstanding = expected_outcomes.size();
            if (end_of_test && !leftovers_checked)
            begin
                leftovers_checked = 1'b1;
                if (expected_outcomes.size() != 0)
                begin
                    report_error($sformatf("%0d results never arrived",
                                           expected_outcomes.size()));
                end
            end
        end
    end

endmodule

[sim/testbench.sv]
module testbench;
    import smtps_pkg::*;

    localparam int unsigned ITEM_TARGET  = 1750;
    localparam int unsigned QUIET_ITEMS  = 150;
    localparam int unsigned HOLD_AT      = 500;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned FLOOD_AT     = 1000;
    localparam int unsigned FLOOD_MAILS  = 260;
    localparam int unsigned CODE_MAX     = 999;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] action;
    logic [9:0] reply_code;
    logic       continued;
    logic       connect_failed;
    logic       out_valid;
    logic       out_stall;
    logic [3:0] command;
    logic       mail_sent;
    logic       mail_dropped;
    logic       queue_overflow;
    logic       unexpected_reply;
    logic [3:0] current_state;
    logic [7:0] pending_count;
    logic       end_of_test;
    int         fail_count;
    int         outstanding;

    int unsigned beats_sent;
    int unsigned gap_percent;
    bit          quiet_tail;
    bit          flood_done;
    bit          hold_done;

    smtp_client_sequencer u_dut (.*);

    smtp_seq_monitor u_monitor (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // offer one event beat, hold it until accepted
    task automatic send_event(input action_t act, input int unsigned code,
                              input int unsigned cont, input int unsigned failed);
        @(negedge clk);
        if (!quiet_tail && $urandom_range(99) < gap_percent)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(negedge clk);
        end
        in_valid       <= 1'b1;
        action         <= act;
        reply_code     <= code[9:0];
        continued      <= cont[0];
        connect_failed <= failed[0];
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        beats_sent++;
    endtask

    task automatic send_mail();
        send_event(ACT_MAIL, $urandom_range(CODE_MAX), $urandom_range(1), $urandom_range(1));
    endtask

    task automatic send_reply(input int unsigned lo, input int unsigned hi);
        send_event(ACT_REPLY, $urandom_range(hi, lo), 0, $urandom_range(1));
    endtask

    task automatic send_continuations();
        if ($urandom_range(3) == 0)
        begin
            repeat ($urandom_range(2, 1))
            begin
                send_event(ACT_REPLY, $urandom_range(CODE_MAX), 1, $urandom_range(1));
            end
        end
    endtask

    task automatic run_session();
        int unsigned turns;
        int unsigned roll;
        bit          dropped;
        send_event(ACT_CLOSED, $urandom_range(CODE_MAX), $urandom_range(1),
                   $urandom_range(1));
        send_mail();
        if ($urandom_range(9) == 0)
        begin
            send_event(ACT_CONNECT, $urandom_range(CODE_MAX), $urandom_range(1), 1);
            return;
        end
        send_event(ACT_CONNECT, $urandom_range(CODE_MAX), $urandom_range(1), 0);
        send_continuations();
        if ($urandom_range(9) == 0)
        begin
            send_reply(CODE_TEMP_FAIL, CODE_MAX);
            return;
        end
        send_reply(0, CODE_TEMP_FAIL - 1);
        send_continuations();
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            send_reply(CODE_TEMP_FAIL, CODE_PERM_FAIL - 1);
            return;
        end
        if (roll < 25)
        begin
            send_reply(CODE_PERM_FAIL, CODE_MAX);
            send_continuations();
            if ($urandom_range(9) == 0)
            begin
                send_reply(CODE_TEMP_FAIL, CODE_MAX);
                return;
            end
        end
        send_reply(0, CODE_TEMP_FAIL - 1);
        turns = $urandom_range(4, 1);
        repeat (turns)
        begin
            if ($urandom_range(2) == 0)
            begin
                send_mail();
            end
            dropped = 1'b0;
            for (int stage = 0; stage < 4 && !dropped; stage++)
            begin
                if ($urandom_range(5) == 0)
                begin
                    send_reply(CODE_TEMP_FAIL, CODE_PERM_FAIL - 1);
                end
                send_continuations();
                if ($urandom_range(99) < 8)
                begin
                    send_reply(CODE_PERM_FAIL, CODE_MAX);
                    send_event(ACT_REPLY, $urandom_range(CODE_MAX), $urandom_range(1),
                               $urandom_range(1));
                    dropped = 1'b1;
                end
                else
                begin
                    send_reply(0, CODE_TEMP_FAIL - 1);
                end
            end
        end
    endtask

    // receiver: random stall bursts, one long hold-off, none in the tail
    initial
    begin
        out_stall = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && beats_sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (quiet_tail)
            begin
                out_stall <= 1'b0;
            end
            else if ($urandom_range(3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(7)) @(negedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat (($urandom_range(4) == 0) ? 60 : $urandom_range(15)) @(negedge clk);
            end
        end
    end

    initial
    begin
        int unsigned pick;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = ACT_REPLY;
        reply_code     = '0;
        continued      = 1'b0;
        connect_failed = 1'b0;
        end_of_test    = 1'b0;
        beats_sent     = 0;
        gap_percent    = 15;
        quiet_tail     = 1'b0;
        flood_done     = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_event(ACT_REPLY, 999, 1, 0);
        send_event(ACT_CONNECT, 0, 0, 1);
        send_event(ACT_CLOSED, 0, 0, 0);
        send_mail();
        send_event(ACT_REPLY, 0, 0, 0);
        send_mail();
        send_event(ACT_CONNECT, 0, 0, 1);
        send_mail();
        send_event(ACT_CONNECT, 0, 0, 0);
        send_event(ACT_REPLY, 421, 0, 0);
        send_mail();
        send_event(ACT_CONNECT, 0, 0, 0);
        send_event(ACT_REPLY, 220, 1, 0);
        send_event(ACT_REPLY, 220, 0, 0);
        send_event(ACT_REPLY, 502, 0, 0);
        send_event(ACT_REPLY, 250, 0, 0);
        send_event(ACT_CONNECT, 0, 0, 0);
        send_event(ACT_REPLY, 451, 0, 0);
        send_event(ACT_REPLY, 250, 0, 0);
        send_event(ACT_REPLY, 550, 0, 0);
        send_event(ACT_REPLY, 999, 1, 1);
        send_event(ACT_REPLY, 250, 0, 0);
        send_event(ACT_REPLY, 250, 0, 0);
        send_event(ACT_REPLY, 354, 0, 0);
        send_event(ACT_REPLY, 250, 0, 0);
        send_event(ACT_CLOSED, 0, 0, 0);

        while (beats_sent < ITEM_TARGET)
        begin
            quiet_tail = (beats_sent > ITEM_TARGET - QUIET_ITEMS);
            case ($urandom_range(2))
                0:       gap_percent = 0;
                1:       gap_percent = 15;
                default: gap_percent = 40;
            endcase
            pick = $urandom_range(99);
            if (!flood_done && beats_sent > FLOOD_AT)
            begin
                flood_done = 1'b1;
                send_event(ACT_CLOSED, $urandom_range(CODE_MAX), $urandom_range(1),
                           $urandom_range(1));
                repeat (FLOOD_MAILS) send_mail();
            end
            else if (pick < 75)
            begin
                run_session();
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(10, 1))
                begin
                    send_event(action_t'($urandom_range(3)), $urandom_range(CODE_MAX),
                               $urandom_range(1), $urandom_range(1));
                end
            end
            else
            begin
                repeat ($urandom_range(5, 1)) send_mail();
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        end_of_test <= 1'b1;
        @(posedge clk);
        @(negedge clk);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
